FILE: hdl/wgm_pkg.sv
// wgm_pkg: shared types and constants of the wildcard glob matcher
package wgm_pkg;

  localparam int unsigned MaxPatternDef = 32;

  localparam logic [7:0] ChAnyOne = 8'd63;
  localparam logic [7:0] ChAnyRun = 8'd42;

  typedef enum logic {
    REQ_PATTERN = 1'b0,
    REQ_TEXT    = 1'b1
  } req_e;

endpackage

FILE: hdl/wildcard_glob_matcher.sv
// wildcard_glob_matcher: streamed text matcher against a '?' and '*' pattern
//
//   channel  valid        stall        payload
//   input    in_valid_i   in_stall_o   req_type_i, char_code_i, last_i
//   output   out_valid_o  out_stall_i  matched_o, pattern_overflow_o, end_of_text_o
//
// one item per cycle while the input is not stalled; a result passes the input register and then the result register
// the row update is one bit-parallel step over the pattern store per text item
// reset clears the row to the empty-text state and opens a pattern load
// a stalled result holds the result register; the input register keeps
// taking items that give no result, and stalls on one that does
module wildcard_glob_matcher #(
  parameter int unsigned MAX_PATTERN = wgm_pkg::MaxPatternDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       req_type_i,
  input  logic [7:0] char_code_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       matched_o,
  output logic       pattern_overflow_o,
  output logic       end_of_text_o
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN + 1);
  localparam int unsigned IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned RowW = MAX_PATTERN + 1;

  // input register
  logic             s1_valid_q, s1_valid_d;
  wgm_pkg::req_e    s1_req_q;
  logic [7:0]       s1_char_q;
  logic             s1_last_q;

  // result register
  logic             out_valid_q, out_valid_d;
  logic             out_matched_q, out_ovf_q, out_end_q;

  // matcher state
  logic [7:0]       store_q [MAX_PATTERN];
  logic [LenW-1:0]  len_q, len_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             loading_q, loading_d;
  logic             ovf_q, ovf_d;

  logic             accept;
  logic             produce;
  logic             out_free;
  logic             s1_fire;
  logic             is_pat;
  logic [LenW-1:0]  len_base;
  logic             ovf_base;
  logic             room;
  logic             wr_cond;
  logic [IdxW-1:0]  wr_idx;
  logic [MAX_PATTERN-1:0] star_nx;
  logic [RowW-1:0]  empty_row;
  logic [RowW-1:0]  next_row;
  logic             res_matched, res_ovf, res_end;

  assign accept     = in_valid_i && !in_stall_o;
  assign is_pat     = (s1_req_q == wgm_pkg::REQ_PATTERN);
  assign produce    = !is_pat || s1_last_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!produce || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;

  assign len_base = loading_q ? len_q : '0;
  assign ovf_base = loading_q ? ovf_q : 1'b0;
  assign room     = (len_base < LenW'(MAX_PATTERN));
  assign wr_cond  = is_pat && room;
  assign wr_idx   = len_base[IdxW-1:0];

  // star flags of the store as it stands after this item's write
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (wr_cond && (wr_idx == IdxW'(k))) begin
        star_nx[k] = (s1_char_q == wgm_pkg::ChAnyRun);
      end else begin
        star_nx[k] = (store_q[k] == wgm_pkg::ChAnyRun);
      end
    end
  end

  // empty-text row: leading run of stars within the pattern length
  always_comb begin
    logic run;
    run = 1'b1;
    empty_row[0] = 1'b1;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      run = run && star_nx[j-1] && (LenW'(j) <= len_d);
      empty_row[j] = run;
    end
  end

  // one text position step of the match row
  always_comb begin
    logic prev;
    logic diag;
    logic up;
    logic hit;
    prev = 1'b0;
    next_row[0] = 1'b0;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      diag = row_q[j-1];
      up   = row_q[j];
      hit  = 1'b0;
      if ((store_q[j-1] == wgm_pkg::ChAnyOne) || (store_q[j-1] == s1_char_q)) begin
        hit = diag;
      end else if (store_q[j-1] == wgm_pkg::ChAnyRun) begin
        hit = diag || prev || up;
      end
      hit = hit && (LenW'(j) <= len_q);
      next_row[j] = hit;
      prev = hit;
    end
  end

  always_comb begin
    len_d     = len_q;
    ovf_d     = ovf_q;
    loading_d = loading_q;
    row_d     = row_q;
    if (is_pat) begin
      len_d = room ? LenW'(len_base + LenW'(1)) : len_base;
      ovf_d = ovf_base || !room;
    end
    if (s1_fire) begin
      if (is_pat) begin
        loading_d = !s1_last_q;
        if (s1_last_q) begin
          row_d = empty_row;
        end
      end else begin
        row_d = s1_last_q ? empty_row : next_row;
      end
    end
  end

  always_comb begin
    if (is_pat) begin
      res_matched = empty_row[len_d];
      res_ovf     = ovf_d;
      res_end     = 1'b1;
    end else begin
      res_matched = next_row[len_q];
      res_ovf     = ovf_q;
      res_end     = s1_last_q;
    end
  end

  assign s1_valid_d  = accept || (s1_valid_q && !s1_fire);
  assign out_valid_d = (s1_fire && produce) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      len_q       <= '0;
      row_q       <= RowW'(1);
      loading_q   <= 1'b1;
      ovf_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        len_q <= len_d;
        ovf_q <= ovf_d;
      end
      row_q     <= row_d;
      loading_q <= loading_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q  <= wgm_pkg::req_e'(req_type_i);
      s1_char_q <= char_code_i;
      s1_last_q <= last_i;
    end
    if (s1_fire && produce) begin
      out_matched_q <= res_matched;
      out_ovf_q     <= res_ovf;
      out_end_q     <= res_end;
    end
    if (s1_fire && wr_cond) begin
      store_q[wr_idx] <= s1_char_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign matched_o          = out_matched_q;
  assign pattern_overflow_o = out_ovf_q;
  assign end_of_text_o      = out_end_q;

endmodule

FILE: hdl/wgm_checker.sv
// wgm_checker: port-level assertions for the wildcard glob matcher, with bind
module wgm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       req_type_i,
  input logic [7:0] char_code_i,
  input logic       last_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       matched_o,
  input logic       pattern_overflow_o,
  input logic       end_of_text_o
);

  logic in_acc;
  logic gives_result;

  assign in_acc       = in_valid_i && !in_stall_o;
  assign gives_result = (req_type_i == wgm_pkg::REQ_TEXT) || last_i;

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // an item that gives a result shows it after the input and result registers when nothing blocks
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && gives_result) ##1 !(out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result missing after accepted item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      ($stable(matched_o) && $stable(pattern_overflow_o) && $stable(end_of_text_o)))
    else $error("result changed while stalled");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);

FILE: tb/sv/wildcard_glob_matcher_tb.sv
// wildcard_glob_matcher_tb: directed and random check of the wildcard glob matcher
module wildcard_glob_matcher_tb;
  import wgm_pkg::*;

  localparam int unsigned MaxPat = MaxPatternDef;

  typedef struct packed {
    logic matched;
    logic overflow;
    logic text_end;
  } match_res_t;

  typedef struct packed {
    req_e       req;
    logic [7:0] ch;
    logic       last_flag;
    logic       typed;
    match_res_t res;
  } dir_row_t;

  localparam int unsigned NumDir = 25;

  localparam dir_row_t DirRows [NumDir] = '{
    '{REQ_TEXT,    8'h61,    1'b0, 1'b1, '{1'b0, 1'b0, 1'b0}},
    '{REQ_TEXT,    8'hff,    1'b1, 1'b1, '{1'b0, 1'b0, 1'b1}},
    '{REQ_PATTERN, ChAnyRun, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1}},
    '{REQ_TEXT,    ChAnyRun, 1'b0, 1'b0, '0},
    '{REQ_TEXT,    8'h00,    1'b1, 1'b0, '0},
    '{REQ_PATTERN, 8'h61,    1'b0, 1'b0, '0},
    '{REQ_PATTERN, ChAnyOne, 1'b0, 1'b0, '0},
    '{REQ_PATTERN, ChAnyRun, 1'b0, 1'b0, '0},
    '{REQ_PATTERN, 8'h62,    1'b1, 1'b1, '{1'b0, 1'b0, 1'b1}},
    '{REQ_TEXT,    8'h61,    1'b0, 1'b0, '0},
    '{REQ_TEXT,    8'h78,    1'b0, 1'b0, '0},
    '{REQ_TEXT,    8'h79,    1'b0, 1'b0, '0},
    '{REQ_TEXT,    8'h62,    1'b1, 1'b0, '0},
    '{REQ_TEXT,    8'h61,    1'b0, 1'b0, '0},
    '{REQ_TEXT,    8'h62,    1'b1, 1'b0, '0},
    '{REQ_PATTERN, 8'h00,    1'b0, 1'b0, '0},
    '{REQ_TEXT,    8'h00,    1'b0, 1'b0, '0},
    '{REQ_PATTERN, 8'hff,    1'b0, 1'b0, '0},
    '{REQ_PATTERN, ChAnyOne, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1}},
    '{REQ_TEXT,    8'h00,    1'b0, 1'b0, '0},
    '{REQ_TEXT,    8'hff,    1'b0, 1'b0, '0},
    '{REQ_TEXT,    ChAnyOne, 1'b1, 1'b0, '0},
    '{REQ_PATTERN, ChAnyRun, 1'b0, 1'b0, '0},
    '{REQ_PATTERN, ChAnyRun, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1}},
    '{REQ_TEXT,    8'h7a,    1'b1, 1'b0, '0}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic       req_type_i;
  logic [7:0] char_code_i;
  logic       last_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       matched_o;
  logic       pattern_overflow_o;
  logic       end_of_text_o;

  wildcard_glob_matcher u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .req_type_i         (req_type_i),
    .char_code_i        (char_code_i),
    .last_i             (last_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .matched_o          (matched_o),
    .pattern_overflow_o (pattern_overflow_o),
    .end_of_text_o      (end_of_text_o)
  );

  logic [7:0]      pat_mem [MaxPat];
  int unsigned     pat_len;
  logic [MaxPat:0] match_row;
  bit              load_open;
  bit              overflow_seen;

  match_res_t  pending_q [$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned send_pct;
  int unsigned recv_pct;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12 * 400000);
    $display("** wildcard_glob_matcher: FAILED **");
    $finish;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_pct);
  end

  // leading run of stars matches empty text
  function automatic logic [MaxPat:0] empty_text_row();
    logic [MaxPat:0] r;
    r = (MaxPat + 1)'(1);
    for (int unsigned j = 1; j <= pat_len; j++) begin
      if (pat_mem[j-1] != ChAnyRun) break;
      r[j] = 1'b1;
    end
    return r;
  endfunction

  function automatic bit step_matcher(input req_e req, input logic [7:0] ch,
                                      input logic last_flag, output match_res_t res);
    logic [MaxPat:0] nxt;
    logic            prev_cur;
    logic            cur;
    logic [7:0]      pc;
    res = '0;
    if (req == REQ_PATTERN) begin
      if (!load_open) begin
        pat_len       = 0;
        overflow_seen = 1'b0;
        load_open     = 1'b1;
      end
      if (pat_len < MaxPat) begin
        pat_mem[pat_len] = ch;
        pat_len++;
      end else begin
        overflow_seen = 1'b1;
      end
      if (!last_flag) return 1'b0;
      load_open = 1'b0;
      match_row = empty_text_row();
      res = '{match_row[pat_len], overflow_seen, 1'b1};
      return 1'b1;
    end
    nxt      = '0;
    prev_cur = 1'b0;
    for (int unsigned j = 1; j <= pat_len; j++) begin
      pc = pat_mem[j-1];
      if (pc == ChAnyOne || pc == ch) cur = match_row[j-1];
      else if (pc == ChAnyRun) cur = match_row[j-1] | prev_cur | match_row[j];
      else cur = 1'b0;
      nxt[j]   = cur;
      prev_cur = cur;
    end
    res       = '{nxt[pat_len], overflow_seen, last_flag};
    match_row = last_flag ? empty_text_row() : nxt;
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_char(input bit wide);
    if (wide) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h63;
      3:       return ChAnyOne;
      default: return ChAnyRun;
    endcase
  endfunction

  task automatic send_item(input req_e req, input logic [7:0] ch, input logic last_flag,
                           input logic typed, input match_res_t typed_res);
    match_res_t res;
    case ((items_sent / 130) % 4)
      0:       begin send_pct = 0;  recv_pct = 0;  end
      1:       begin send_pct = 57; recv_pct = 0;  end
      2:       begin send_pct = 0;  recv_pct = 57; end
      default: begin send_pct = 31; recv_pct = 31; end
    endcase
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    char_code_i <= ch;
    last_i      <= last_flag;
    do @(posedge clk_i); while (in_stall_o);
    if (step_matcher(req, ch, last_flag, res)) pending_q.push_back(typed ? typed_res : res);
    items_sent++;
  endtask

  always @(posedge clk_i) begin
    match_res_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result: matched %0b overflow %0b end %0b",
               matched_o, pattern_overflow_o, end_of_text_o);
        errors++;
      end else begin
        exp_res = pending_q.pop_front();
        if (matched_o !== exp_res.matched) begin
          $error("matched: expected %0b, got %0b", exp_res.matched, matched_o);
          errors++;
        end
        if (pattern_overflow_o !== exp_res.overflow) begin
          $error("pattern_overflow: expected %0b, got %0b", exp_res.overflow,
                 pattern_overflow_o);
          errors++;
        end
        if (end_of_text_o !== exp_res.text_end) begin
          $error("end_of_text: expected %0b, got %0b", exp_res.text_end, end_of_text_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned len;
    int unsigned nstr;
    int unsigned slen;
    int unsigned guard;
    bit          wide;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = 1'b0;
    char_code_i   = 8'h00;
    last_i        = 1'b0;
    out_stall_i   = 1'b0;
    pat_len       = 0;
    match_row     = (MaxPat + 1)'(1);
    load_open     = 1'b1;
    overflow_seen = 1'b0;
    errors        = 0;
    items_sent    = 0;
    send_pct      = 0;
    recv_pct      = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirRows[i])
      send_item(DirRows[i].req, DirRows[i].ch, DirRows[i].last_flag, DirRows[i].typed,
                DirRows[i].res);

    while (items_sent < 1050) begin
      if ($urandom_range(0, 3) != 0) begin
        wide = ($urandom_range(0, 5) == 0);
        len  = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        for (int unsigned k = 0; k < len; k++)
          send_item(REQ_PATTERN, pick_char(wide), k == len - 1, 1'b0, '0);
        nstr = $urandom_range(1, 4);
        for (int unsigned s = 0; s < nstr; s++) begin
          slen = $urandom_range(1, 12);
          for (int unsigned k = 0; k < slen; k++)
            send_item(REQ_TEXT, pick_char(wide), k == slen - 1, 1'b0, '0);
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int unsigned k = 0; k < len; k++)
          send_item(req_e'($urandom_range(0, 1)), pick_char($urandom_range(0, 1)),
                    $urandom_range(0, 1), 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    recv_pct = 0;
    for (guard = 0; guard < 20000 && pending_q.size() != 0; guard++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_q.size() != 0) begin
      $error("%0d expected results never arrived", pending_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("** wildcard_glob_matcher: PASSED **");
    end else begin
      $display("** wildcard_glob_matcher: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/wgm_pkg.sv
hdl/wildcard_glob_matcher.sv
hdl/wgm_checker.sv
tb/sv/wildcard_glob_matcher_tb.sv
